### hdl/char_lcd_bus_sequencer_assert.svh
// ----------------------------------------------------------------------------
// char lcd bus sequencer assertion macros
// concurrent checks that compile away in synthesis
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_BUS_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_BUS_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CLBS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("clbs check failed");

// next-cycle implication
`define CLBS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("clbs check failed");

`else

`define CLBS_ASSERT_IMPLY(label, clk, rst, cond, prop)

`define CLBS_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

### hdl/clbs_pkg.sv
// ----------------------------------------------------------------------------
// clbs_pkg
// types, codes and phase update shared by the lcd bus sequencer
// ----------------------------------------------------------------------------
package clbs_pkg;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_CMD    = 3'd1,
      OP_DATA   = 3'd2,
      OP_CURSOR = 3'd3,
      OP_INIT   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_TICK = 2'd0,
      ST_OK   = 2'd1,
      ST_BUSY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_SETUP    = 3'd0,
      CSR_ENABLE   = 3'd1,
      CSR_SHORT    = 3'd2,
      CSR_LONG     = 3'd3,
      CSR_POWER_UP = 3'd4,
      CSR_FUNC_SET = 3'd5
   } csr_index_type;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_PWR   = 6'b000010,
      PH_SETUP = 6'b000100,
      PH_EN    = 6'b001000,
      PH_HOLD  = 6'b010000,
      PH_FSET  = 6'b100000
   } phase_type;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;

   localparam logic [2:0] INIT_NONE  = 3'd0;
   localparam logic [2:0] INIT_PWR   = 3'd1;
   localparam logic [2:0] INIT_FSET  = 3'd2;
   localparam logic [2:0] INIT_DISP  = 3'd3;
   localparam logic [2:0] INIT_MODE  = 3'd4;
   localparam logic [2:0] INIT_CLEAR = 3'd5;

   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_HOME      = 8'h02;
   localparam logic [7:0] CMD_ENTRY     = 8'h06;
   localparam logic [7:0] CMD_DISPLAY   = 8'h0C;
   localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
   localparam logic [7:0] CMD_ROW0_BASE = 8'h80;
   localparam logic [7:0] CMD_ROW1_BASE = 8'hC0;

   localparam logic [7:0]  RST_SETUP    = 8'd2;
   localparam logic [7:0]  RST_ENABLE   = 8'd2;
   localparam logic [15:0] RST_SHORT    = 16'd100;
   localparam logic [15:0] RST_LONG     = 16'd3000;
   localparam logic [15:0] RST_POWER_UP = 16'd20000;
   localparam logic [15:0] RST_FUNC_SET = 16'd5000;

   // a tick chain ends at enable or idle within four phase changes
   // (enable, hold, function-set wait, setup, enable)
   localparam int unsigned SettleSteps = 4;

   typedef struct packed {
      logic [7:0]  setup_ticks;
      logic [7:0]  enable_ticks;
      logic [15:0] short_wait_ticks;
      logic [15:0] long_wait_ticks;
      logic [15:0] power_up_ticks;
      logic [15:0] function_set_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] countdown;
      logic [7:0]  latched_byte;
      logic        latched_rs;
      logic        enable_level;
      logic [2:0]  init_step;
   } state_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] byte_value;
      logic       row;
      logic [5:0] col;
   } req_word_type;

   typedef struct packed {
      logic       rs_pin;
      logic       en_pin;
      logic [7:0] data_bus;
      logic       busy_res;
      logic [1:0] status;
   } rsp_word_type;

   function automatic state_type start_write(state_type s, cfg_type c,
                                             logic [7:0] b, logic rs);
      state_type n;
      n              = s;
      n.latched_byte = b;
      n.latched_rs   = rs;
      n.phase        = PH_SETUP;
      n.countdown    = {8'd0, c.setup_ticks};
      n.enable_level = 1'b0;
      return n;
   endfunction

   function automatic state_type advance(state_type s, cfg_type c);
      state_type n;
      n = s;
      case (s.phase)
         PH_PWR: begin
            n           = start_write(s, c, CMD_FUNC_SET, 1'b0);
            n.init_step = INIT_FSET;
         end
         PH_SETUP: begin
            n.phase        = PH_EN;
            n.countdown    = {8'd0, (c.enable_ticks == 8'd0) ? 8'd1 : c.enable_ticks};
            n.enable_level = 1'b1;
         end
         PH_EN: begin
            n.phase        = PH_HOLD;
            n.enable_level = 1'b0;
            if (!s.latched_rs && (s.latched_byte == CMD_CLEAR ||
                                  s.latched_byte == CMD_HOME)) begin
               n.countdown = c.long_wait_ticks;
            end else begin
               n.countdown = c.short_wait_ticks;
            end
         end
         PH_HOLD: begin
            if (s.init_step == INIT_FSET) begin
               n.phase        = PH_FSET;
               n.countdown    = c.function_set_ticks;
               n.enable_level = 1'b0;
            end else if (s.init_step == INIT_DISP) begin
               n           = start_write(s, c, CMD_ENTRY, 1'b0);
               n.init_step = INIT_MODE;
            end else if (s.init_step == INIT_MODE) begin
               n           = start_write(s, c, CMD_CLEAR, 1'b0);
               n.init_step = INIT_CLEAR;
            end else begin
               n.init_step    = INIT_NONE;
               n.phase        = PH_IDLE;
               n.countdown    = 16'd0;
               n.enable_level = 1'b0;
            end
         end
         PH_FSET: begin
            n           = start_write(s, c, CMD_DISPLAY, 1'b0);
            n.init_step = INIT_DISP;
         end
         default: begin
            n.init_step    = INIT_NONE;
            n.phase        = PH_IDLE;
            n.countdown    = 16'd0;
            n.enable_level = 1'b0;
         end
      endcase
      return n;
   endfunction

endpackage

### hdl/clbs_if.sv
// ----------------------------------------------------------------------------
// clbs channel interfaces
// valid/ready channels for request and response words
// ----------------------------------------------------------------------------
interface clbs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [7:0] byte_value;
   logic       row;
   logic [5:0] col;

   modport source (output valid, output operation, output byte_value, output row,
                   output col, input ready);
   modport sink   (input valid, input operation, input byte_value, input row,
                   input col, output ready);
endinterface

interface clbs_rsp_if;
   logic       valid;
   logic       ready;
   logic       rs_pin;
   logic       en_pin;
   logic [7:0] data_bus;
   logic       busy_res;
   logic [1:0] status;

   modport source (output valid, output rs_pin, output en_pin, output data_bus,
                   output busy_res, output status, input ready);
   modport sink   (input valid, input rs_pin, input en_pin, input data_bus,
                   input busy_res, input status, output ready);
endinterface

### hdl/clbs_step.sv
// ----------------------------------------------------------------------------
// clbs_step
// next bus state and response word for one request word
// ----------------------------------------------------------------------------
module clbs_step
   import clbs_pkg::*;
(
   input  state_type    cur,
   input  cfg_type      cfg,
   input  req_word_type req,
   output state_type    nxt,
   output rsp_word_type rsp
);

   state_type  pre;
   state_type  chain [SettleSteps+1];
   logic       run;
   logic [1:0] status;
   logic [7:0] cursor_byte;

   assign cursor_byte = (req.row ? CMD_ROW1_BASE : CMD_ROW0_BASE) + {2'b00, req.col};

   always_comb begin
      pre    = cur;
      run    = 1'b0;
      status = ST_TICK;
      case (req.operation)
         OP_CMD, OP_DATA, OP_CURSOR, OP_INIT: begin
            if (cur.phase != PH_IDLE) begin
               status = ST_BUSY;
            end else begin
               status = ST_OK;
               run    = 1'b1;
               case (req.operation)
                  OP_CMD:    pre = start_write(cur, cfg, req.byte_value, 1'b0);
                  OP_DATA:   pre = start_write(cur, cfg, req.byte_value, 1'b1);
                  OP_CURSOR: pre = start_write(cur, cfg, cursor_byte, 1'b0);
                  default: begin
                     pre.init_step    = INIT_PWR;
                     pre.latched_rs   = 1'b0;
                     pre.phase        = PH_PWR;
                     pre.countdown    = cfg.power_up_ticks;
                     pre.enable_level = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            // ticks and unused codes only count down a running phase
            if (cur.phase != PH_IDLE) begin
               pre.countdown = cur.countdown - 16'd1;
               run           = 1'b1;
            end
         end
      endcase
   end

   // zero-length phases fall through in the same word
   always_comb begin
      chain[0] = pre;
      for (int i = 0; i < SettleSteps; i++) begin
         if (run && chain[i].phase != PH_IDLE && chain[i].countdown == 16'd0) begin
            chain[i+1] = advance(chain[i], cfg);
         end else begin
            chain[i+1] = chain[i];
         end
      end
   end

   assign nxt          = chain[SettleSteps];
   assign rsp.rs_pin   = nxt.latched_rs;
   assign rsp.en_pin   = nxt.enable_level;
   assign rsp.data_bus = nxt.latched_byte;
   assign rsp.busy_res = (nxt.phase != PH_IDLE);
   assign rsp.status   = status;

endmodule

### hdl/char_lcd_bus_sequencer.sv
// a request word passes from the request register through the step logic into
// the response register, which loads only while the response channel is free
// throughput: one word per cycle unless the response channel stalls, set by the
// single-pass step logic between the request register and the response register
// reset: synchronous active high; bus state idle, timing registers to defaults
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer
// 8-bit character lcd bus sequencer with timing registers
// ----------------------------------------------------------------------------
`include "char_lcd_bus_sequencer_assert.svh"

module char_lcd_bus_sequencer
   import clbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   clbs_req_if.sink                 req_ch,
   clbs_rsp_if.source               rsp_ch,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   state_type    state_ff, state_in;
   req_word_type req_word_ff;
   logic         req_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         rsp_valid_ff;
   logic         rsp_free;
   logic         step_go;
   logic         req_take;
   state_type    step_nxt;
   req_word_type req_word_in;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign step_go  = req_valid_ff && rsp_free;
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !req_valid_ff || step_go;

   assign req_word_in.operation  = req_ch.operation;
   assign req_word_in.byte_value = req_ch.byte_value;
   assign req_word_in.row        = req_ch.row;
   assign req_word_in.col        = req_ch.col;

   clbs_step u_step (
      .cur (state_ff),
      .cfg (cfg_ff),
      .req (req_word_ff),
      .nxt (step_nxt),
      .rsp (rsp_word_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SETUP:    cfg_in.setup_ticks        = csr_wdata[7:0];
            CSR_ENABLE:   cfg_in.enable_ticks       = csr_wdata[7:0];
            CSR_SHORT:    cfg_in.short_wait_ticks   = csr_wdata;
            CSR_LONG:     cfg_in.long_wait_ticks    = csr_wdata;
            CSR_POWER_UP: cfg_in.power_up_ticks     = csr_wdata;
            CSR_FUNC_SET: cfg_in.function_set_ticks = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   assign state_in = step_go ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setup_ticks        <= RST_SETUP;
         cfg_ff.enable_ticks       <= RST_ENABLE;
         cfg_ff.short_wait_ticks   <= RST_SHORT;
         cfg_ff.long_wait_ticks    <= RST_LONG;
         cfg_ff.power_up_ticks     <= RST_POWER_UP;
         cfg_ff.function_set_ticks <= RST_FUNC_SET;
         state_ff.phase            <= PH_IDLE;
         state_ff.countdown        <= 16'd0;
         state_ff.latched_byte     <= 8'd0;
         state_ff.latched_rs       <= 1'b0;
         state_ff.enable_level     <= 1'b0;
         state_ff.init_step        <= INIT_NONE;
         req_valid_ff              <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
         if (req_ch.ready) begin
            req_valid_ff <= req_ch.valid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_word_ff <= req_word_in;
      end
      if (step_go) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.rs_pin   = rsp_word_ff.rs_pin;
   assign rsp_ch.en_pin   = rsp_word_ff.en_pin;
   assign rsp_ch.data_bus = rsp_word_ff.data_bus;
   assign rsp_ch.busy_res = rsp_word_ff.busy_res;
   assign rsp_ch.status   = rsp_word_ff.status;

   // a running phase never rests on a zero count
   `CLBS_ASSERT_IMPLY(a_settled, clock, reset, state_ff.phase != PH_IDLE, state_ff.countdown != 16'd0)
   // the strobe is high exactly in the enable phase
   `CLBS_ASSERT_IMPLY(a_strobe, clock, reset, 1'b1, state_ff.enable_level == (state_ff.phase == PH_EN))
   // a rejected request only happens while the bus is busy
   `CLBS_ASSERT_IMPLY(a_reject, clock, reset, rsp_valid_ff && rsp_word_ff.status == ST_BUSY, rsp_word_ff.busy_res)
   // a word held by a stalled response register leaves the bus state alone
   `CLBS_ASSERT_NEXT(a_hold, clock, reset, req_valid_ff && !rsp_free, state_ff == $past(state_ff))

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench for char_lcd_bus_sequencer
// drives request words (ticks, commands, data, cursor moves, initialize),
// keeps a cycle-free model of the lcd bus timing and checks every response
// word field by field, with random gaps on both channels
// ----------------------------------------------------------------------------
module testbench;
   import clbs_pkg::*;

   localparam int unsigned CycleLimit  = 100000;
   localparam int unsigned RandomWords = 400;
   localparam int unsigned PhaseWords  = 150;
   localparam int unsigned GapPercent  = 27;
   localparam int unsigned DrainCycles = 4;

   // operation codes outside the defined set behave as ticks
   localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
   localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   clbs_req_if req_ch ();
   clbs_rsp_if rsp_ch ();

   char_lcd_bus_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // timing registers as the bus model sees them
   logic [7:0]  t_setup, t_enable;
   logic [15:0] t_short, t_long, t_power, t_fset;

   // bus model state
   phase_type   bus_phase;
   logic [15:0] ticks_left;
   logic [7:0]  bus_byte;
   logic        bus_rs;
   logic        bus_en;
   logic [2:0]  init_seq;

   rsp_word_type expected_bus_q [$];

   bit          no_gaps;
   int          error_count;
   int          words_sent;
   int unsigned cycle_count;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= no_gaps || ($urandom_range(99) >= GapPercent);
   end

   // ------------------------------------------------------------------------
   // bus model
   // ------------------------------------------------------------------------
   function automatic void enter_phase(phase_type ph, logic [15:0] n);
      bus_phase  = ph;
      ticks_left = n;
      bus_en     = (ph == PH_EN);
   endfunction

   function automatic void start_bus_write(logic [7:0] b, logic rs);
      bus_byte = b;
      bus_rs   = rs;
      enter_phase(PH_SETUP, {8'd0, t_setup});
   endfunction

   function automatic void next_bus_phase();
      case (bus_phase)
         PH_PWR: begin
            init_seq = INIT_FSET;
            start_bus_write(CMD_FUNC_SET, 1'b0);
         end
         PH_SETUP: begin
            // a zero enable count still shows e high for one tick
            enter_phase(PH_EN, (t_enable == 8'd0) ? 16'd1 : {8'd0, t_enable});
         end
         PH_EN: begin
            if (!bus_rs && (bus_byte == CMD_CLEAR || bus_byte == CMD_HOME)) begin
               enter_phase(PH_HOLD, t_long);
            end else begin
               enter_phase(PH_HOLD, t_short);
            end
         end
         PH_HOLD: begin
            if (init_seq == INIT_FSET) begin
               enter_phase(PH_FSET, t_fset);
            end else if (init_seq == INIT_DISP) begin
               init_seq = INIT_MODE;
               start_bus_write(CMD_ENTRY, 1'b0);
            end else if (init_seq == INIT_MODE) begin
               init_seq = INIT_CLEAR;
               start_bus_write(CMD_CLEAR, 1'b0);
            end else begin
               init_seq = INIT_NONE;
               enter_phase(PH_IDLE, 16'd0);
            end
         end
         PH_FSET: begin
            init_seq = INIT_DISP;
            start_bus_write(CMD_DISPLAY, 1'b0);
         end
         default: begin
            init_seq = INIT_NONE;
            enter_phase(PH_IDLE, 16'd0);
         end
      endcase
   endfunction

   function automatic rsp_word_type predict_bus(logic [2:0] op, logic [7:0] b, logic r,
                                                logic [5:0] c);
      rsp_word_type w;
      status_type   st;
      st = ST_TICK;
      if (op == OP_CMD || op == OP_DATA || op == OP_CURSOR || op == OP_INIT) begin
         if (bus_phase != PH_IDLE) begin
            st = ST_BUSY;
         end else begin
            st = ST_OK;
            case (op)
               OP_CMD:    start_bus_write(b, 1'b0);
               OP_DATA:   start_bus_write(b, 1'b1);
               OP_CURSOR: start_bus_write((r ? CMD_ROW1_BASE : CMD_ROW0_BASE) + {2'd0, c},
                                          1'b0);
               default: begin
                  // data pins keep the last byte through power-up
                  init_seq = INIT_PWR;
                  bus_rs   = 1'b0;
                  enter_phase(PH_PWR, t_power);
               end
            endcase
         end
      end else if (bus_phase != PH_IDLE) begin
         ticks_left = ticks_left - 16'd1;
      end
      // zero-length phases fall through at once
      while (bus_phase != PH_IDLE && ticks_left == 16'd0) next_bus_phase();
      w.rs_pin   = bus_rs;
      w.en_pin   = bus_en;
      w.data_bus = bus_byte;
      w.busy_res = (bus_phase != PH_IDLE);
      w.status   = st;
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
               want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_words
      rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bus_q.size() == 0) begin
            report_mismatch("response word with nothing expected", rsp_ch.data_bus, 8'd0);
         end else begin
            want = expected_bus_q.pop_front();
            if (rsp_ch.rs_pin !== want.rs_pin)
               report_mismatch("rs_pin", {7'd0, rsp_ch.rs_pin}, {7'd0, want.rs_pin});
            if (rsp_ch.en_pin !== want.en_pin)
               report_mismatch("en_pin", {7'd0, rsp_ch.en_pin}, {7'd0, want.en_pin});
            if (rsp_ch.data_bus !== want.data_bus)
               report_mismatch("data_bus", rsp_ch.data_bus, want.data_bus);
            if (rsp_ch.busy_res !== want.busy_res)
               report_mismatch("busy_res", {7'd0, rsp_ch.busy_res}, {7'd0, want.busy_res});
            if (rsp_ch.status !== want.status)
               report_mismatch("status", {6'd0, rsp_ch.status}, {6'd0, want.status});
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   // returns right after the accepting edge; the next caller drives at the
   // following falling edge
   task automatic send_word(input logic [2:0] op, input logic [7:0] b, input logic r,
                            input logic [5:0] c);
      @(negedge clock);
      while (!no_gaps && $urandom_range(99) < GapPercent) begin
         req_ch.valid      <= 1'b0;
         req_ch.operation  <= 3'($urandom);
         req_ch.byte_value <= 8'($urandom);
         req_ch.row        <= 1'($urandom);
         req_ch.col        <= 6'($urandom);
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.byte_value <= b;
      req_ch.row        <= r;
      req_ch.col        <= c;
      do @(posedge clock); while (!req_ch.ready);
      expected_bus_q.push_back(predict_bus(op, b, r, c));
      words_sent++;
   endtask

   function automatic logic [2:0] tick_code();
      logic [2:0] op;
      op = OP_TICK;
      if ($urandom_range(7) == 0) op = 3'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST));
      return op;
   endfunction

   function automatic logic [7:0] command_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) b = $urandom_range(1) ? CMD_HOME : CMD_CLEAR;
      return b;
   endfunction

   // ticks until the bus goes idle, with stray requests that must bounce
   task automatic run_bus_idle();
      logic [2:0] op;
      while (bus_phase != PH_IDLE) begin
         op = tick_code();
         if ($urandom_range(9) == 0) op = 3'($urandom_range(OP_INIT, OP_CMD));
         send_word(op, command_byte(), 1'($urandom), 6'($urandom));
      end
   endtask

   task automatic drain_words();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_bus_q.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic put_csr(input csr_index_type idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   // a running bus sequence keeps its current count; new values apply from
   // the next phase on
   task automatic set_timing(input logic [7:0] s, input logic [7:0] e,
                             input logic [15:0] sh, input logic [15:0] lg,
                             input logic [15:0] pw, input logic [15:0] fs);
      drain_words();
      put_csr(CSR_SETUP, {8'd0, s});
      put_csr(CSR_ENABLE, {8'd0, e});
      put_csr(CSR_SHORT, sh);
      put_csr(CSR_LONG, lg);
      put_csr(CSR_POWER_UP, pw);
      put_csr(CSR_FUNC_SET, fs);
      csr_we   <= 1'b0;
      t_setup  = s;
      t_enable = e;
      t_short  = sh;
      t_long   = lg;
      t_power  = pw;
      t_fset   = fs;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_default_timing();
      send_word(OP_DATA, 8'h41, 1'b0, 6'd0);
      run_bus_idle();
   endtask

   task automatic test_each_request();
      set_timing(8'd1, 8'd1, 16'd2, 16'd3, 16'd4, 16'd2);
      send_word(OP_CMD, 8'h00, 1'b1, 6'h3F);
      send_word(OP_DATA, 8'h55, 1'b0, 6'd0);
      run_bus_idle();
      send_word(OP_CMD, 8'hFF, 1'b0, 6'd0);
      run_bus_idle();
      send_word(OP_CMD, CMD_CLEAR, 1'b0, 6'd0);
      run_bus_idle();
      send_word(OP_CMD, CMD_HOME, 1'b0, 6'd0);
      run_bus_idle();
      // data 0x01 is a character, so it takes the short wait
      send_word(OP_DATA, CMD_CLEAR, 1'b0, 6'd0);
      run_bus_idle();
      send_word(OP_DATA, 8'hFF, 1'b1, 6'h3F);
      run_bus_idle();
      send_word(OP_CURSOR, 8'hFF, 1'b0, 6'd0);
      run_bus_idle();
      send_word(OP_CURSOR, 8'h00, 1'b1, 6'h3F);
      send_word(OP_UNDEF_FIRST, 8'h00, 1'b0, 6'd0);
      send_word(OP_UNDEF_LAST, 8'hFF, 1'b1, 6'h3F);
      run_bus_idle();
      send_word(OP_UNDEF_LAST, 8'h12, 1'b0, 6'd5);
      send_word(OP_TICK, 8'h34, 1'b1, 6'd9);
   endtask

   task automatic test_init_sequence();
      set_timing(8'd1, 8'd2, 16'd3, 16'd5, 16'd6, 16'd4);
      send_word(OP_INIT, 8'h00, 1'b0, 6'd0);
      send_word(OP_INIT, 8'hFF, 1'b1, 6'h3F);
      run_bus_idle();
   endtask

   task automatic test_zero_counts();
      set_timing(8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_word(OP_CMD, CMD_CLEAR, 1'b0, 6'd0);
      run_bus_idle();
      send_word(OP_DATA, 8'hA5, 1'b0, 6'd0);
      run_bus_idle();
      send_word(OP_INIT, 8'h00, 1'b0, 6'd0);
      run_bus_idle();
   endtask

   task automatic test_midrun_registers();
      set_timing(8'd2, 8'd2, 16'd6, 16'd6, 16'd8, 16'd4);
      send_word(OP_INIT, 8'h00, 1'b0, 6'd0);
      repeat (3) send_word(OP_TICK, 8'h00, 1'b0, 6'd0);
      set_timing(8'd0, 8'd3, 16'd1, 16'd2, 16'd5, 16'd1);
      run_bus_idle();
   endtask

   task automatic test_widest_counts();
      set_timing(8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0);
      send_word(OP_CMD, 8'h55, 1'b0, 6'd0);
      run_bus_idle();
      // a wait past one byte of count runs without gaps on either channel
      no_gaps = 1'b1;
      set_timing(8'd0, 8'd1, 16'h0100, 16'h0101, 16'h0102, 16'h0103);
      send_word(OP_DATA, 8'hAA, 1'b0, 6'd0);
      run_bus_idle();
      drain_words();
      no_gaps = 1'b0;
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int phase_end;
      int pick;
      stop_at = words_sent + RandomWords;
      while (words_sent < stop_at) begin
         set_timing(8'($urandom_range(3)), 8'($urandom_range(3)),
                    16'($urandom_range(6)), 16'($urandom_range(12)),
                    16'($urandom_range(10)), 16'($urandom_range(8)));
         phase_end = words_sent + PhaseWords;
         while (words_sent < phase_end && words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 10)
               send_word(OP_INIT, 8'($urandom), 1'($urandom), 6'($urandom));
            else if (pick < 35)
               send_word(OP_CMD, command_byte(), 1'($urandom), 6'($urandom));
            else if (pick < 65)
               send_word(OP_DATA, 8'($urandom), 1'($urandom), 6'($urandom));
            else if (pick < 85)
               send_word(OP_CURSOR, 8'($urandom), 1'($urandom), 6'($urandom));
            else
               send_word(tick_code(), 8'($urandom), 1'($urandom), 6'($urandom));
            // sometimes leave the bus busy so the next request lands mid-write
            if ($urandom_range(4) == 0)
               repeat ($urandom_range(4))
                  send_word(tick_code(), 8'($urandom), 1'($urandom), 6'($urandom));
            else
               run_bus_idle();
         end
      end
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_SETUP;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.operation  = OP_TICK;
      req_ch.byte_value = 8'd0;
      req_ch.row        = 1'b0;
      req_ch.col        = 6'd0;
      rsp_ch.ready      = 1'b0;
      no_gaps           = 1'b0;
      error_count       = 0;
      words_sent        = 0;
      cycle_count       = 0;
      t_setup           = RST_SETUP;
      t_enable          = RST_ENABLE;
      t_short           = RST_SHORT;
      t_long            = RST_LONG;
      t_power           = RST_POWER_UP;
      t_fset            = RST_FUNC_SET;
      bus_phase         = PH_IDLE;
      ticks_left        = 16'd0;
      bus_byte          = 8'd0;
      bus_rs            = 1'b0;
      bus_en            = 1'b0;
      init_seq          = INIT_NONE;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_default_timing();
      test_each_request();
      test_init_sequence();
      test_zero_counts();
      test_midrun_registers();
      test_widest_counts();
      test_random_traffic();

      drain_words();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
